FILE: hw/rtl/chorus_delay_modulator_assert.svh
// Assertion macros shared by the chorus delay modulator RTL.
`ifndef CHORUS_DELAY_MODULATOR_ASSERT_SVH
`define CHORUS_DELAY_MODULATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge of i_clk outside reset.
`define CDM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chorus delay modulator assertion failed");

// Next-cycle implication, checked at every rising edge of i_clk outside reset.
`define CDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chorus delay modulator assertion failed");

`endif

FILE: hw/rtl/cdm_pkg.sv
// Shared types, constants and the sine table of the chorus delay modulator.
package cdm_pkg;

    localparam int CHANNELS     = 2;
    localparam int SINE_ENTRIES = 1024;
    localparam int SIDX_W       = $clog2(SINE_ENTRIES);
    localparam int FRAC_BITS    = 8;
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 16;
    localparam int DELAY_W      = 20;
    localparam int PHASE_W      = 32;
    localparam int COUNT_W      = 2;
    localparam int BUFLEN_W     = 13;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_DELAY      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEPTH_SPAN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_INCREMENT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WET_GAIN        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN        = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BUFFER_LENGTH   = 3'd6;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_lanes;
    typedef logic signed [SAMPLE_W-1:0] t_sine_rom [SINE_ENTRIES];

    // Commands from the controller, at most one high in any cycle.
    typedef struct packed {
        logic load;
        logic mul;
        logic dly;
        logic pos;
        logic rd0;
        logic rd1;
        logic wet;
        logic mwet;
        logic sum;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

    // Quarter-wave Taylor evaluation in Q30, folded to a full turn.
    function automatic t_sine_rom f_build_sine();
        t_sine_rom         rom;
        longint unsigned   p;
        longint unsigned   r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        longint unsigned   v;
        longint unsigned   quad;
        logic [SAMPLE_W-1:0] vv;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            p    = (longint'(i) << 32) / SINE_ENTRIES;
            quad = (p >> 30) & 64'd3;
            r    = p & 64'd1073741823;
            if (quad[0]) begin
                r = 64'd1073741824 - r;
            end
            x  = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824 - x2 / 110;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            v  = (s * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            vv = v[SAMPLE_W-1:0];
            rom[i] = quad[1] ? -$signed(vv) : $signed(vv);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

endpackage

FILE: hw/rtl/cdm_store.sv
// Delay store: one sample memory per channel, one write and one registered read a cycle.
module cdm_store
    import cdm_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                          i_clk,
    input  logic [CHANNELS-1:0]           i_we,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_waddr,
    input  t_lanes                        i_wdata,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_raddr,
    output t_lanes                        o_rdata
);

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        logic [SAMPLE_W-1:0] r_mem [MAX_FRAMES];
        logic [SAMPLE_W-1:0] r_rdata;

        always_ff @(posedge i_clk) begin
            if (i_we[ch]) begin
                r_mem[i_waddr] <= i_wdata[ch];
            end
            r_rdata <= r_mem[i_raddr];
        end

        assign o_rdata[ch] = r_rdata;
    end

endmodule

FILE: hw/rtl/cdm_ctrl.sv
// Sequencing state machine of the chorus delay modulator.
module cdm_ctrl
    import cdm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DLY   = 4'd3;
    localparam logic [3:0] S_POS   = 4'd4;
    localparam logic [3:0] S_RD0   = 4'd5;
    localparam logic [3:0] S_RD1   = 4'd6;
    localparam logic [3:0] S_WET   = 4'd7;
    localparam logic [3:0] S_MWET  = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DLY;
            end
            S_DLY: begin
                o_cmd.dly = 1'b1;
                n_state   = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_WET;
            end
            S_WET: begin
                o_cmd.wet = 1'b1;
                n_state   = S_MWET;
            end
            S_MWET: begin
                o_cmd.mwet = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.sum = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/cdm_datapath.sv
// Datapath: LFO, delay arithmetic, store access, interpolation, mixing and result register.
module cdm_datapath
    import cdm_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic [COUNT_W-1:0]         i_channel_count,
    input  logic [DELAY_W-1:0]         i_base_delay,
    input  logic [DELAY_W-1:0]         i_depth_span,
    input  logic [PHASE_W-1:0]         i_phase_increment,
    input  logic [GAIN_W-1:0]          i_wet_gain,
    input  logic [GAIN_W-1:0]          i_dry_gain,
    input  logic [BUFLEN_W-1:0]        i_buffer_length,
    input  logic                       i_input_present,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch1,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_out_ch0,
    output logic signed [SAMPLE_W-1:0] o_out_ch1
);

    localparam int AW    = $clog2(MAX_FRAMES);
    localparam int LENW  = AW + 1;
    localparam int LIMW  = LENW + FRAC_BITS;
    localparam int RDW   = LIMW + 1;
    localparam int PRODW = SAMPLE_W + DELAY_W + 1;
    localparam int DSW   = (LIMW + 1 > PRODW - 14) ? LIMW + 1 : PRODW - 14;
    localparam int DRYW  = SAMPLE_W + GAIN_W + 1;
    localparam int WETW  = SAMPLE_W + FRAC_BITS + 2;
    localparam int WPW   = WETW + GAIN_W + 1;
    localparam int ACW   = WPW + 2;
    localparam int SHIFT = SAMPLE_W - 1 + FRAC_BITS;

    // Configuration must be stable whenever an item is in flight; this block does not enforce it.
    logic [31:0]     len_full;
    logic [LENW-1:0] len;
    logic [LIMW-1:0] limit;
    logic            chan_two;

    always_comb begin
        if (i_buffer_length == '0) begin
            len_full = 32'd1;
        end else if (32'(i_buffer_length) > 32'(MAX_FRAMES)) begin
            len_full = 32'(MAX_FRAMES);
        end else begin
            len_full = 32'(i_buffer_length);
        end
    end

    assign len      = len_full[LENW-1:0];
    assign limit    = {len, {FRAC_BITS{1'b0}}};
    assign chan_two = i_channel_count[1];

    logic [PHASE_W-1:0]                        r_phase;
    logic [AW-1:0]                             r_wp;
    logic [AW-1:0]                             r_clr_addr;
    logic signed [SAMPLE_W-1:0]                r_sine;
    logic signed [CHANNELS-1:0][SAMPLE_W-1:0]  r_samp;
    logic signed [PRODW-1:0]                   r_prod;
    logic signed [CHANNELS-1:0][DRYW-1:0]      r_dry;
    logic [LIMW-1:0]                           r_delay;
    logic [LIMW-1:0]                           r_rd;
    logic [AW-1:0]                             r_p1;
    t_lanes                                    r_s0;
    logic signed [CHANNELS-1:0][WETW-1:0]      r_wet;
    logic signed [CHANNELS-1:0][WPW-1:0]       r_wprod;
    logic                                      r_out_valid;
    logic signed [CHANNELS-1:0][SAMPLE_W-1:0]  r_out;

    // Store ports.
    logic [CHANNELS-1:0] st_we;
    logic [AW-1:0]       st_waddr;
    t_lanes              st_wdata;
    logic [AW-1:0]       st_raddr;
    t_lanes              st_rdata;

    cdm_store #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    // Write position as corrected against a shortened length.
    logic [AW-1:0] wp_eff;
    assign wp_eff = ({1'b0, r_wp} >= len) ? '0 : r_wp;

    // Delay sum and clamp.
    logic signed [DSW-1:0] dsum;
    logic signed [DSW-1:0] limit_s;
    logic [LIMW-1:0]       delay_c;

    always_comb begin
        dsum    = DSW'($signed({1'b0, i_base_delay})) + DSW'(r_prod >>> (SAMPLE_W - 1));
        limit_s = DSW'($signed({1'b0, limit}));
        if (dsum < 0) begin
            delay_c = '0;
        end else if (dsum > limit_s) begin
            delay_c = limit;
        end else begin
            delay_c = LIMW'(dsum);
        end
    end

    // Read position.
    logic signed [RDW-1:0] rdiff;
    logic [LIMW-1:0]       rd_c;

    always_comb begin
        rdiff = RDW'($signed({1'b0, r_wp, {FRAC_BITS{1'b0}}}))
              - RDW'($signed({1'b0, r_delay}));
        if (rdiff < 0) begin
            rd_c = LIMW'(rdiff + RDW'($signed({1'b0, limit})));
        end else begin
            rd_c = LIMW'(rdiff);
        end
    end

    // Neighbouring store rows.
    logic [LENW-1:0] p0_raw;
    logic [LENW-1:0] p0;
    logic [LENW-1:0] p1_raw;
    logic [FRAC_BITS-1:0] frac;

    assign p0_raw = r_rd[LIMW-1:FRAC_BITS];
    assign p0     = (p0_raw >= len) ? len - 1'b1 : p0_raw;
    assign p1_raw = p0 + 1'b1;
    assign frac   = r_rd[FRAC_BITS-1:0];

    always_comb begin
        st_we    = '0;
        st_waddr = r_wp;
        st_wdata = r_samp;
        if (i_cmd.clr) begin
            st_we    = '1;
            st_waddr = r_clr_addr;
            st_wdata = '0;
        end else if (i_cmd.pos) begin
            st_we = {chan_two, 1'b1};
        end
        st_raddr = i_cmd.rd0 ? AW'(p0) : r_p1;
    end

    // Per-lane interpolation and mix. Lane selects of the packed arrays are
    // unsigned, so each one is reinterpreted as signed where it is used.
    logic signed [CHANNELS-1:0][SAMPLE_W:0]   diff;
    logic signed [CHANNELS-1:0][WETW-1:0]     wet_c;
    logic signed [CHANNELS-1:0][ACW-1:0]      acc;
    logic signed [CHANNELS-1:0][ACW-SHIFT-1:0] acc_sh;
    logic signed [CHANNELS-1:0][SAMPLE_W-1:0] sat;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            diff[ch]   = $signed({st_rdata[ch][SAMPLE_W-1], st_rdata[ch]})
                       - $signed({r_s0[ch][SAMPLE_W-1], r_s0[ch]});
            wet_c[ch]  = (WETW'($signed(r_s0[ch])) <<< FRAC_BITS)
                       + WETW'($signed(diff[ch]) * $signed({1'b0, frac}));
            acc[ch]    = (ACW'($signed(r_dry[ch])) <<< FRAC_BITS)
                       + ACW'($signed(r_wprod[ch]))
                       + (ACW'(1) <<< (SHIFT - 1));
            acc_sh[ch] = (ACW-SHIFT)'($signed(acc[ch]) >>> SHIFT);
            if ($signed(acc_sh[ch]) > (ACW-SHIFT)'(32767)) begin
                sat[ch] = 16'sh7FFF;
            end else if ($signed(acc_sh[ch]) < -(ACW-SHIFT)'(32768)) begin
                sat[ch] = -16'sh8000;
            end else begin
                sat[ch] = SAMPLE_W'(acc_sh[ch]);
            end
        end
    end

    logic [LENW-1:0] wp_next;
    assign wp_next = {1'b0, r_wp} + 1'b1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_wp        <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_phase <= r_phase + i_phase_increment;
                r_wp    <= wp_eff;
            end
            if (i_cmd.sum) begin
                r_wp        <= (wp_next >= len) ? '0 : AW'(wp_next);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sine    <= SINE_ROM[r_phase[PHASE_W-1 -: SIDX_W]];
            r_samp[0] <= i_input_present ? i_sample_ch0 : '0;
            r_samp[1] <= i_input_present ? i_sample_ch1 : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= r_sine * $signed({1'b0, i_depth_span});
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_dry[ch] <= $signed(r_samp[ch]) * $signed({1'b0, i_dry_gain});
            end
        end
        if (i_cmd.dly) begin
            r_delay <= delay_c;
        end
        if (i_cmd.pos) begin
            r_rd <= rd_c;
        end
        if (i_cmd.rd0) begin
            r_p1 <= (p1_raw >= len) ? '0 : AW'(p1_raw);
        end
        if (i_cmd.rd1) begin
            r_s0 <= st_rdata;
        end
        if (i_cmd.wet) begin
            r_wet <= wet_c;
        end
        if (i_cmd.mwet) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_wprod[ch] <= $signed(r_wet[ch]) * $signed({1'b0, i_wet_gain});
            end
        end
        if (i_cmd.sum) begin
            r_out[0] <= sat[0];
            r_out[1] <= chan_two ? sat[1] : '0;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(MAX_FRAMES - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_ch0       = r_out[0];
    assign o_out_ch1       = r_out[1];

endmodule

FILE: hw/rtl/chorus_delay_modulator.sv
// Chorus delay modulator: LFO-modulated delay line with dry/wet mix, APB register file.
//
// One input beat carries a frame of up to two signed Q1.15 samples plus a presence
// flag; one output beat carries the two mixed, saturated Q1.15 results (channel one
// reads zero in mono). A beat moves on a rising edge where valid is high and stall
// is low. Each frame is processed in turn by a controller stepping a shared datapath;
// the result is registered at the end of the sequence, and the next input beat is
// taken only after that. The sequencer steps are: sine lookup, two multiplies, the
// delay clamp, the store write, two reads of the single store read port and the mix
// stages.
// A finished result waits in the output register while the receiver stalls; the
// next frame is accepted meanwhile and only its final mix step waits for room.
// After reset the delay store is swept to zero, one row per cycle through every row,
// with the input held stalled; register writes are taken throughout.
// Registers live at byte address 4*i in the order channel_count, base_delay,
// depth_span, phase_increment, wet_gain, dry_gain, buffer_length, and must only be
// written while no frame is in flight; the block itself does not enforce this.
module chorus_delay_modulator
    import cdm_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_input_present,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_W-1:0] i_sample_ch1,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_ch0,
    output logic signed [SAMPLE_W-1:0] o_out_ch1
);

    // Register file.
    logic [COUNT_W-1:0]  r_channel_count;
    logic [DELAY_W-1:0]  r_base_delay;
    logic [DELAY_W-1:0]  r_depth_span;
    logic [PHASE_W-1:0]  r_phase_increment;
    logic [GAIN_W-1:0]   r_wet_gain;
    logic [GAIN_W-1:0]   r_dry_gain;
    logic [BUFLEN_W-1:0] r_buffer_length;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count   <= 2'd2;
            r_base_delay      <= 20'd307200;
            r_depth_span      <= 20'd24576;
            r_phase_increment <= 32'd44739;
            r_wet_gain        <= 16'd16384;
            r_dry_gain        <= 16'd16384;
            r_buffer_length   <= 13'd1344;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHANNEL_COUNT:   r_channel_count   <= pwdata[COUNT_W-1:0];
                REG_BASE_DELAY:      r_base_delay      <= pwdata[DELAY_W-1:0];
                REG_DEPTH_SPAN:      r_depth_span      <= pwdata[DELAY_W-1:0];
                REG_PHASE_INCREMENT: r_phase_increment <= pwdata[PHASE_W-1:0];
                REG_WET_GAIN:        r_wet_gain        <= pwdata[GAIN_W-1:0];
                REG_DRY_GAIN:        r_dry_gain        <= pwdata[GAIN_W-1:0];
                REG_BUFFER_LENGTH:   r_buffer_length   <= pwdata[BUFLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the register file; unused addresses read as zero.
    always_comb begin
        unique case (reg_idx)
            REG_CHANNEL_COUNT:   prdata = PDATA_W'(r_channel_count);
            REG_BASE_DELAY:      prdata = PDATA_W'(r_base_delay);
            REG_DEPTH_SPAN:      prdata = PDATA_W'(r_depth_span);
            REG_PHASE_INCREMENT: prdata = r_phase_increment;
            REG_WET_GAIN:        prdata = PDATA_W'(r_wet_gain);
            REG_DRY_GAIN:        prdata = PDATA_W'(r_dry_gain);
            REG_BUFFER_LENGTH:   prdata = PDATA_W'(r_buffer_length);
            default:             prdata = '0;
        endcase
    end

    // Controller and datapath exchange only commands and status.
    t_cmd  w_cmd;
    t_stat w_stat;

    cdm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (o_in_stall)
    );

    cdm_datapath #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_channel_count  (r_channel_count),
        .i_base_delay     (r_base_delay),
        .i_depth_span     (r_depth_span),
        .i_phase_increment(r_phase_increment),
        .i_wet_gain       (r_wet_gain),
        .i_dry_gain       (r_dry_gain),
        .i_buffer_length  (r_buffer_length),
        .i_input_present  (i_input_present),
        .i_sample_ch0     (i_sample_ch0),
        .i_sample_ch1     (i_sample_ch1),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_ch0        (o_out_ch0),
        .o_out_ch1        (o_out_ch1)
    );

`include "chorus_delay_modulator_assert.svh"

    // The sequencer never issues two steps at once.
    `CDM_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(w_cmd))
    // No beat is taken while the store is being swept.
    `CDM_ASSERT_NOW(a_stall_in_clear, w_cmd.clr, o_in_stall)
    // A taken beat starts the multiply step in the next cycle.
    `CDM_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, w_cmd.mul)
    // A result is only written when the output register has room.
    `CDM_ASSERT_NOW(a_sum_has_room, w_cmd.sum, w_stat.out_free)

endmodule
